// ===== src/dvrc_pkg.sv =====
// ---------------------------------------------------------------------------
// dvrc_pkg
// Shared types, VR codes and lookup functions for the DICOM VR value checker.
// ---------------------------------------------------------------------------
package dvrc_pkg;

    localparam int VR_BITS        = 6;
    localparam int NUM_STRING_VRS = 17;
    localparam int FIFO_DEPTH     = 4;
    localparam int PTR_BITS       = 2;

    localparam logic [VR_BITS-1:0] VR_AE = 6'd0;
    localparam logic [VR_BITS-1:0] VR_AS = 6'd1;
    localparam logic [VR_BITS-1:0] VR_CS = 6'd2;
    localparam logic [VR_BITS-1:0] VR_DA = 6'd3;
    localparam logic [VR_BITS-1:0] VR_DS = 6'd4;
    localparam logic [VR_BITS-1:0] VR_DT = 6'd5;
    localparam logic [VR_BITS-1:0] VR_IS = 6'd6;
    localparam logic [VR_BITS-1:0] VR_LO = 6'd7;
    localparam logic [VR_BITS-1:0] VR_LT = 6'd8;
    localparam logic [VR_BITS-1:0] VR_PN = 6'd9;
    localparam logic [VR_BITS-1:0] VR_SH = 6'd10;
    localparam logic [VR_BITS-1:0] VR_ST = 6'd11;
    localparam logic [VR_BITS-1:0] VR_TM = 6'd12;
    localparam logic [VR_BITS-1:0] VR_UI = 6'd14;
    localparam logic [VR_BITS-1:0] VR_FL = 6'd17;
    localparam logic [VR_BITS-1:0] VR_FD = 6'd18;
    localparam logic [VR_BITS-1:0] VR_SL = 6'd19;
    localparam logic [VR_BITS-1:0] VR_SS = 6'd20;
    localparam logic [VR_BITS-1:0] VR_SV = 6'd21;
    localparam logic [VR_BITS-1:0] VR_UL = 6'd22;
    localparam logic [VR_BITS-1:0] VR_US = 6'd23;
    localparam logic [VR_BITS-1:0] VR_UV = 6'd24;
    localparam logic [VR_BITS-1:0] VR_AT = 6'd31;
    localparam logic [VR_BITS-1:0] VR_UN = 6'd33;

    localparam logic [VR_BITS-1:0] VR_STR_END = 6'd17;

    // classified word passed from front to back
    typedef struct packed {
        logic               func;
        logic [VR_BITS-1:0] vr;
        logic               class_ok;
        logic               unit_ok;
        logic               has;
        logic               last;
    } dvrc_word_t;

    function automatic logic [VR_BITS-1:0] norm_vr(input logic [VR_BITS-1:0] code);
        return (code > VR_UN) ? VR_UN : code;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_unit(input logic [7:0] b);
        return (b == 8'h44) || (b == 8'h57) || (b == 8'h4D) || (b == 8'h59);
    endfunction

    function automatic logic byte_in_class(input logic [VR_BITS-1:0] vr,
                                           input logic [7:0] b);
        logic ok;
        ok = 1'b1;
        unique case (vr)
            VR_CS: ok = ((b >= 8'h41) && (b <= 8'h5A)) || is_digit(b) ||
                        (b == 8'h20) || (b == 8'h5F);
            VR_DA: ok = is_digit(b);
            VR_TM: ok = is_digit(b) || (b == 8'h2E) || (b == 8'h3A);
            VR_UI: ok = is_digit(b) || (b == 8'h2E);
            VR_DS: ok = is_digit(b) || (b == 8'h2B) || (b == 8'h2D) ||
                        (b == 8'h2E) || (b == 8'h45) || (b == 8'h65) ||
                        (b == 8'h20);
            VR_IS: ok = is_digit(b) || (b == 8'h2B) || (b == 8'h2D);
            VR_AS: ok = is_digit(b) || is_unit(b);
            VR_DT: ok = is_digit(b) || (b == 8'h2E) || (b == 8'h2B) ||
                        (b == 8'h2D);
            default:
            begin
                if (vr < VR_STR_END)
                    ok = ((b >= 8'h20) && (b <= 8'h7E)) || (b == 8'h0D) ||
                         (b == 8'h0A) || (b == 8'h0C) || (b == 8'h09);
                else
                    ok = 1'b1;
            end
        endcase
        return ok;
    endfunction

    // maximum length, 0 = unlimited or not a string VR
    function automatic logic [15:0] max_len(input logic [VR_BITS-1:0] vr);
        logic [15:0] m;
        unique case (vr)
            VR_AE:   m = 16'd16;
            VR_AS:   m = 16'd4;
            VR_CS:   m = 16'd16;
            VR_DA:   m = 16'd8;
            VR_DS:   m = 16'd16;
            VR_DT:   m = 16'd26;
            VR_IS:   m = 16'd12;
            VR_LO:   m = 16'd64;
            VR_LT:   m = 16'd10240;
            VR_PN:   m = 16'd324;
            VR_SH:   m = 16'd16;
            VR_ST:   m = 16'd1024;
            VR_TM:   m = 16'd14;
            VR_UI:   m = 16'd64;
            default: m = 16'd0;
        endcase
        return m;
    endfunction

    // fixed item size, 0 = not fixed
    function automatic logic [3:0] unit_size(input logic [VR_BITS-1:0] vr);
        logic [3:0] u;
        unique case (vr)
            VR_AS, VR_FL, VR_SL, VR_UL, VR_AT: u = 4'd4;
            VR_DA, VR_FD, VR_SV, VR_UV:        u = 4'd8;
            VR_SS, VR_US:                      u = 4'd2;
            default:                           u = 4'd0;
        endcase
        return u;
    endfunction

endpackage

// ===== src/dvrc_front.sv =====
// ---------------------------------------------------------------------------
// dvrc_front
// Input stage: takes a byte word, classifies it and hands it to the queue.
// ---------------------------------------------------------------------------
module dvrc_front
    import dvrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               func,
    input  logic [VR_BITS-1:0] vr_code,
    input  logic [7:0]         data_byte,
    input  logic               has_byte,
    input  logic               last,
    output logic               q_push,
    output dvrc_word_t         q_word,
    input  logic               q_full
);

    logic               valid_reg;
    logic               valid_next;
    dvrc_word_t         word_reg;
    dvrc_word_t         word_next;
    logic               accept;
    logic [VR_BITS-1:0] vr_n;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_word = word_reg;

    always_comb
    begin
        vr_n               = norm_vr(vr_code);
        word_next.func     = func;
        word_next.vr       = vr_n;
        word_next.class_ok = byte_in_class(vr_n, data_byte);
        word_next.unit_ok  = is_unit(data_byte);
        word_next.has      = has_byte;
        word_next.last     = last;
        if (accept)
            valid_next = 1'b1;
        else if (q_push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            word_reg <= word_next;
    end

endmodule

// ===== src/dvrc_fifo.sv =====
// ---------------------------------------------------------------------------
// dvrc_fifo
// Short queue of classified words between the front and back stages.
// ---------------------------------------------------------------------------
module dvrc_fifo
    import dvrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  dvrc_word_t wr_word,
    output logic       q_full,
    output logic       rd_en_ok,
    input  logic       rd_en,
    output dvrc_word_t rd_word
);

    dvrc_word_t          mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS:0]   cnt_reg;
    logic [PTR_BITS:0]   cnt_next;

    assign q_full   = (cnt_reg == (PTR_BITS+1)'(FIFO_DEPTH));
    assign rd_en_ok = (cnt_reg != '0);
    assign rd_word  = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_word;
    end

endmodule

// ===== src/dvrc_back.sv =====
// ---------------------------------------------------------------------------
// dvrc_back
// Accumulates length and class flags per value and forms the verdict.
// ---------------------------------------------------------------------------
module dvrc_back
    import dvrc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_avail,
    input  dvrc_word_t q_word,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic       valid_res
);

    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    logic [2:0]            mod_reg;
    logic [2:0]            mod_next;
    logic                  chars_reg;
    logic                  chars_next;
    logic                  age_reg;
    logic                  age_next;
    logic                  res_valid_reg;
    logic                  res_reg;
    logic                  verdict;
    logic                  is_str;
    logic                  over;
    logic                  charset;
    logic [3:0]            unit;
    logic [15:0]           maxl;

    assign empty     = !res_valid_reg;
    assign valid_res = res_reg;
    assign q_pop     = q_avail && (!q_word.last || !res_valid_reg || pop);

    always_comb
    begin
        cnt_next   = cnt_reg;
        mod_next   = mod_reg;
        chars_next = chars_reg;
        age_next   = age_reg;
        if (q_word.has)
        begin
            if (!q_word.class_ok)
                chars_next = 1'b0;
            if (cnt_reg == COUNT_BITS'(3))
                age_next = q_word.unit_ok;
            if (cnt_reg != '1)
                cnt_next = cnt_reg + COUNT_BITS'(1);
            mod_next = mod_reg + 3'd1;
        end

        is_str = (q_word.vr < VR_STR_END);
        unit   = unit_size(q_word.vr);
        maxl   = max_len(q_word.vr);
        over   = is_str && (maxl != 16'd0) && (cnt_next > COUNT_BITS'(maxl));

        if (q_word.vr == VR_AS)
            charset = (cnt_next == COUNT_BITS'(4)) && chars_next && age_next;
        else if (q_word.vr == VR_DA)
            charset = (cnt_next == COUNT_BITS'(8)) && chars_next;
        else if (is_str)
            charset = chars_next;
        else
            charset = 1'b1;

        if (!q_word.func)
        begin
            if (unit != 4'd0)
                verdict = ((mod_next & 3'(unit - 4'd1)) == 3'd0);
            else if (is_str)
                verdict = !over && charset;
            else
                verdict = 1'b1;
        end
        else
        begin
            if (!is_str || over)
                verdict = 1'b0;
            else if ((unit != 4'd0) && (cnt_next != COUNT_BITS'(unit)))
                verdict = 1'b0;
            else
                verdict = charset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            mod_reg       <= '0;
            chars_reg     <= 1'b1;
            age_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                if (q_word.last)
                begin
                    cnt_reg   <= '0;
                    mod_reg   <= '0;
                    chars_reg <= 1'b1;
                    age_reg   <= 1'b0;
                    res_reg   <= verdict;
                end
                else
                begin
                    cnt_reg   <= cnt_next;
                    mod_reg   <= mod_next;
                    chars_reg <= chars_next;
                    age_reg   <= age_next;
                end
            end
            if (q_pop && q_word.last)
                res_valid_reg <= 1'b1;
            else if (pop && res_valid_reg)
                res_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== src/dicom_vr_value_checker_top.sv =====
// ---------------------------------------------------------------------------
// dicom_vr_value_checker_top
// Checks a streamed DICOM element value against its value representation.
//
//   channel   direction  handshake       payload
//   input     in         push / full     func, vr_code, data_byte, has_byte, last
//   result    out        empty / pop     valid_res
//
// One byte word per cycle while pop keeps up; a word passes the front register,
// a four-entry queue and the back accumulator, and a verdict is registered in
// the result register once the last word leaves the queue. Reset clears all stages; stalls on
// pop back up through the result register and queue to full.
// ---------------------------------------------------------------------------
module dicom_vr_value_checker_top
    import dvrc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               func,
    input  logic [VR_BITS-1:0] vr_code,
    input  logic [7:0]         data_byte,
    input  logic               has_byte,
    input  logic               last,
    output logic               empty,
    input  logic               pop,
    output logic               valid_res
);

    logic       q_push;
    logic       q_full;
    logic       q_avail;
    logic       q_pop;
    dvrc_word_t front_word;
    dvrc_word_t back_word;

    dvrc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .vr_code   (vr_code),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .last      (last),
        .q_push    (q_push),
        .q_word    (front_word),
        .q_full    (q_full)
    );

    dvrc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_word  (front_word),
        .q_full   (q_full),
        .rd_en_ok (q_avail),
        .rd_en    (q_pop),
        .rd_word  (back_word)
    );

    dvrc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_avail   (q_avail),
        .q_word    (back_word),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .valid_res (valid_res)
    );

endmodule

// ===== tb/dvrc_tb_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dvrc_tb_pkg
// VR codes and per-VR length rules shared by the VR checker testbench.
// ---------------------------------------------------------------------------
package dvrc_tb_pkg;

    import dvrc_pkg::*;

    localparam logic [VR_BITS-1:0] VR_CODE_TOP = 6'd63;

    // 0 means no limit
    function automatic logic [15:0] vr_max_len(input logic [VR_BITS-1:0] code);
        case (code)
            VR_AE, VR_CS, VR_DS, VR_SH: return 16'd16;
            VR_AS:                      return 16'd4;
            VR_DA:                      return 16'd8;
            VR_DT:                      return 16'd26;
            VR_IS:                      return 16'd12;
            VR_LO, VR_UI:               return 16'd64;
            VR_LT:                      return 16'd10240;
            VR_PN:                      return 16'd324;
            VR_ST:                      return 16'd1024;
            VR_TM:                      return 16'd14;
            default:                    return 16'd0;
        endcase
    endfunction

    function automatic logic [3:0] vr_unit(input logic [VR_BITS-1:0] code);
        case (code)
            VR_AS, VR_FL, VR_SL, VR_UL, VR_AT: return 4'd4;
            VR_DA, VR_FD, VR_SV, VR_UV:        return 4'd8;
            VR_SS, VR_US:                      return 4'd2;
            default:                           return 4'd0;
        endcase
    endfunction

endpackage

// ===== tb/dvrc_verdict_check.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dvrc_verdict_check
// Watches both queue channels of the VR checker, works out the verdict of
// every value from the words taken in and compares it with each verdict popped.
// ---------------------------------------------------------------------------
module dvrc_verdict_check
    import dvrc_pkg::*;
    import dvrc_tb_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic               func,
    input  logic [VR_BITS-1:0] vr_code,
    input  logic [7:0]         data_byte,
    input  logic               has_byte,
    input  logic               last,
    input  logic               empty,
    input  logic               pop,
    input  logic               valid_res,
    output int                 errors,
    output int                 outstanding,
    output int                 verdicts_seen,
    output int                 verdicts_true
);

    logic [COUNT_BITS-1:0] byte_tally  = '0;
    logic [2:0]            tally_mod8  = '0;
    logic                  class_clean = 1'b1;
    logic                  unit_seen   = 1'b0;
    logic                  due_verdicts[$];
    int                    mismatches  = 0;
    int                    seen        = 0;
    int                    trues       = 0;

    function automatic logic age_unit(input logic [7:0] b);
        return b == "D" || b == "W" || b == "M" || b == "Y";
    endfunction

    function automatic logic fits_class(input logic [VR_BITS-1:0] code, input logic [7:0] b);
        logic dig;
        dig = b >= "0" && b <= "9";
        case (code)
            VR_CS:   return dig || (b >= "A" && b <= "Z") || b == " " || b == "_";
            VR_DA:   return dig;
            VR_TM:   return dig || b == "." || b == ":";
            VR_UI:   return dig || b == ".";
            VR_DS:   return dig || b == "+" || b == "-" || b == "." || b == "E" ||
                            b == "e" || b == " ";
            VR_IS:   return dig || b == "+" || b == "-";
            VR_AS:   return dig || age_unit(b);
            VR_DT:   return dig || b == "." || b == "+" || b == "-";
            default: return code >= VR_STR_END || (b >= 8'h20 && b <= 8'h7E) ||
                            b == 8'h0D || b == 8'h0A || b == 8'h0C || b == 8'h09;
        endcase
    endfunction

    function automatic logic judge_value(input logic f, input logic [VR_BITS-1:0] code,
                                         input logic [COUNT_BITS-1:0] n,
                                         input logic [2:0] n8, input logic clean,
                                         input logic unit_ok);
        logic [3:0]  sz;
        logic [15:0] lim;
        logic        text_ok;
        logic        is_str;
        sz      = vr_unit(code);
        lim     = vr_max_len(code);
        is_str  = code < VR_STR_END;
        text_ok = clean;
        if (code == VR_AS)
            text_ok = clean && unit_ok && n == 4;
        else if (code == VR_DA)
            text_ok = clean && n == 8;
        if (!is_str)
            text_ok = 1'b1;
        if (!f)
        begin
            if (sz != 0)
                return (n8 & 3'(sz - 1)) == 0;
            if (!is_str)
                return 1'b1;
            if (lim != 0 && n > lim)
                return 1'b0;
            return text_ok;
        end
        if (!is_str)
            return 1'b0;
        if (lim != 0 && n > lim)
            return 1'b0;
        if (sz != 0 && n != sz)
            return 1'b0;
        return text_ok;
    endfunction

    always @(posedge clk)
    begin : watch
        logic [VR_BITS-1:0] code;
        logic               want;
        if (!rst_n)
        begin
            byte_tally  = '0;
            tally_mod8  = '0;
            class_clean = 1'b1;
            unit_seen   = 1'b0;
            due_verdicts.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                seen++;
                if (valid_res === 1'b1)
                    trues++;
                if (due_verdicts.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("verdict %0d: none expected, got %b", seen, valid_res);
                    mismatches++;
                end
                else
                begin
                    want = due_verdicts.pop_front();
                    if (valid_res !== want)
                    begin
                        if (mismatches < 10)
                            $display("verdict %0d: expected %b, got %b",
                                     seen, want, valid_res);
                        mismatches++;
                    end
                end
            end
            if (push && !full)
            begin
                code = (vr_code > VR_UN) ? VR_UN : vr_code;
                if (has_byte)
                begin
                    if (!fits_class(code, data_byte))
                        class_clean = 1'b0;
                    if (byte_tally == 3)
                        unit_seen = age_unit(data_byte);
                    if (byte_tally != '1)
                        byte_tally = byte_tally + 1'b1;
                    tally_mod8 = tally_mod8 + 3'd1;
                end
                if (last)
                begin
                    due_verdicts.insert(due_verdicts.size(),
                                        judge_value(func, code, byte_tally, tally_mod8,
                                                    class_clean, unit_seen));
                    byte_tally  = '0;
                    tally_mod8  = '0;
                    class_clean = 1'b1;
                    unit_seen   = 1'b0;
                end
            end
        end
        errors        <= mismatches;
        outstanding   <= due_verdicts.size();
        verdicts_seen <= seen;
        verdicts_true <= trues;
    end

endmodule

// ===== tb/dicom_vr_value_checker_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dicom_vr_value_checker_top_test
// Streams DICOM element values into the VR checker under varying idle and
// stall mixes; verdicts are predicted and compared by dvrc_verdict_check.
// ---------------------------------------------------------------------------
module dicom_vr_value_checker_top_test;

    import dvrc_pkg::*;
    import dvrc_tb_pkg::*;

    localparam int COUNT_W         = 16;
    localparam int WORDS_PER_PHASE = 280;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               push      = 1'b0;
    logic               full;
    logic               func      = 1'b0;
    logic [VR_BITS-1:0] vr_code   = '0;
    logic [7:0]         data_byte = '0;
    logic               has_byte  = 1'b0;
    logic               last      = 1'b0;
    logic               empty;
    logic               pop       = 1'b0;
    logic               valid_res;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int words_sent    = 0;
    int values_sent   = 0;
    int errors;
    int outstanding;
    int verdicts_seen;
    int verdicts_true;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dicom_vr_value_checker_top #(.COUNT_BITS(COUNT_W)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .vr_code   (vr_code),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .last      (last),
        .empty     (empty),
        .pop       (pop),
        .valid_res (valid_res)
    );

    dvrc_verdict_check #(.COUNT_BITS(COUNT_W)) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .func          (func),
        .vr_code       (vr_code),
        .data_byte     (data_byte),
        .has_byte      (has_byte),
        .last          (last),
        .empty         (empty),
        .pop           (pop),
        .valid_res     (valid_res),
        .errors        (errors),
        .outstanding   (outstanding),
        .verdicts_seen (verdicts_seen),
        .verdicts_true (verdicts_true)
    );

    always @(posedge clk)
        pop <= ($urandom_range(99) >= stall_pct);

    task automatic put_word(input logic f, input logic [VR_BITS-1:0] code,
                            input logic [7:0] b, input logic has, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        func      <= f;
        vr_code   <= code;
        data_byte <= b;
        has_byte  <= has;
        last      <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_value(input logic f, input logic [VR_BITS-1:0] code,
                              input string s);
        if (s.len() == 0)
            put_word(f, code, 8'($urandom_range(255)), 1'b0, 1'b1);
        else
            for (int i = 0; i < s.len(); i++)
                put_word(f, code, s[i], 1'b1, i == s.len() - 1);
        values_sent++;
    endtask

    // a byte from the VR's own character class; age unit in the fourth AS byte
    function automatic logic [7:0] legal_byte(input logic [VR_BITS-1:0] code, input int pos);
        string pool;
        case (code)
            VR_CS: pool = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 _";
            VR_DA: pool = "0123456789";
            VR_TM: pool = "0123456789.:";
            VR_UI: pool = "0123456789.";
            VR_DS: pool = "0123456789+-.Ee ";
            VR_IS: pool = "0123456789+-";
            VR_DT: pool = "0123456789.+-";
            VR_AS:
            begin
                if (pos == 3)
                    pool = "DWMY";
                else
                    pool = "0123456789";
            end
            default:
            begin
                if (code >= VR_STR_END)
                    return 8'($urandom_range(255));
                if ($urandom_range(9) != 0)
                    return 8'($urandom_range(8'h7E, 8'h20));
                case ($urandom_range(3))
                    0:       return 8'h09;
                    1:       return 8'h0A;
                    2:       return 8'h0C;
                    default: return 8'h0D;
                endcase
            end
        endcase
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    task automatic random_value();
        logic               f;
        logic               tail_empty;
        logic [VR_BITS-1:0] code;
        logic [VR_BITS-1:0] word_code;
        logic [7:0]         b;
        logic [15:0]        lim;
        int                 n;
        f          = 1'($urandom_range(1));
        tail_empty = ($urandom_range(19) == 0);
        if ($urandom_range(99) < 8)
            code = 6'($urandom_range(VR_CODE_TOP, VR_UN + 1));
        else
            code = 6'($urandom_range(VR_UN));
        lim = vr_max_len(code);
        if ((code == VR_AS || code == VR_DA) && $urandom_range(1) == 1)
            n = lim;
        else if (lim != 0 && lim <= 64 && $urandom_range(2) == 0)
            n = $urandom_range(lim + 2, lim - 1);
        else
            n = $urandom_range(16);
        if (n == 0)
            put_word(f, code, 8'($urandom_range(255)), 1'b0, 1'b1);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(24) == 0)
                put_word(f, code, 8'($urandom_range(255)), 1'b0, 1'b0);
            word_code = ($urandom_range(29) == 0) ? 6'($urandom_range(VR_CODE_TOP)) : code;
            b = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : legal_byte(code, i);
            put_word(f, word_code, b, 1'b1, i == n - 1 && !tail_empty);
        end
        if (n != 0 && tail_empty)
            put_word(f, code, 8'($urandom_range(255)), 1'b0, 1'b1);
        values_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        int start;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_value(1'b1, VR_CS, "");
        send_value(1'b1, VR_AS, "012Y");
        send_value(1'b1, VR_DA, "12345678");
        put_word(1'b0, VR_CODE_TOP, 8'hFF, 1'b1, 1'b0);
        put_word(1'b0, VR_CODE_TOP, 8'h00, 1'b1, 1'b1);
        put_word(1'b1, VR_CODE_TOP, 8'hFF, 1'b1, 1'b1);
        put_word(1'b1, VR_ST, "a", 1'b1, 1'b0);
        put_word(1'b1, VR_CS, "A", 1'b1, 1'b1);
        put_word(1'b1, VR_CS, "a", 1'b1, 1'b0);
        put_word(1'b1, VR_ST, 8'h0A, 1'b1, 1'b1);
        put_word(1'b0, VR_SS, 8'($urandom_range(255)), 1'b0, 1'b0);
        put_word(1'b0, VR_SS, 8'h12, 1'b1, 1'b0);
        put_word(1'b0, VR_SS, 8'h34, 1'b1, 1'b1);
        values_sent += 5;

        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1:
                begin
                    send_idle_pct = 70;
                    stall_pct    <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 70;
                end
                default:
                begin
                    send_idle_pct = 23;
                    stall_pct    <= 23;
                end
            endcase
            start = words_sent;
            while (words_sent - start < WORDS_PER_PHASE)
                random_value();
        end
        drain();

        $display("sent %0d words in %0d values, limits and odd codes included",
                 words_sent, values_sent);
        $display("checked %0d verdicts, %0d true, across four idle and stall mixes",
                 verdicts_seen, verdicts_true);
        if (errors == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d verdicts outstanding", outstanding);
        $display("status: fail");
        $finish;
    end

endmodule
